/* sv/plc_pkg.sv */
// Package for the positional list engine: beat types, command and status
// codes, the control word broadcast to the cell chain and default sizes.
// No dependencies.
package plc_pkg;

  localparam int unsigned CapacityDef   = 16;
  localparam int unsigned EntryWidthDef = 32;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_PEND = 2'd2
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  position;
    logic [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [3:0]  found_index;
    logic [4:0]  entry_count;
  } out_beat_t;

  // Control word seen by every cell.
  typedef struct packed {
    logic [2:0] cmd;
    logic [4:0] pos;
    logic       do_ins;
    logic       do_rem;
  } cell_ctl_t;

  // Flags of the scan token that walks the chain.
  typedef struct packed {
    logic valid;
    logic found;
  } tok_flags_t;

endpackage

/* sv/plc_cell.sv */
// One cell of the list chain: holds one entry, shifts it to or from its
// neighbors on insert and remove, and serves the scan token as it passes.
// Depends on plc_pkg.
module plc_cell import plc_pkg::*; #(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned ENTRY_WIDTH = EntryWidthDef,
  parameter int unsigned INDEX       = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cell_ctl_t                        ctl_i,
  input  logic [$clog2(CAPACITY+1)-1:0]    count_i,
  input  logic [ENTRY_WIDTH-1:0]           value_i,
  input  logic [ENTRY_WIDTH-1:0]           left_i,
  input  logic [ENTRY_WIDTH-1:0]           right_i,
  output logic [ENTRY_WIDTH-1:0]           entry_o,
  input  tok_flags_t                       tok_flags_i,
  input  logic [$clog2(CAPACITY)-1:0]      tok_idx_i,
  input  logic [ENTRY_WIDTH-1:0]           tok_data_i,
  output tok_flags_t                       tok_flags_o,
  output logic [$clog2(CAPACITY)-1:0]      tok_idx_o,
  output logic [ENTRY_WIDTH-1:0]           tok_data_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = (CntW > 5) ? CntW : 5;

  logic [ENTRY_WIDTH-1:0] entry_q, entry_d;
  tok_flags_t             flags_q, flags_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [ENTRY_WIDTH-1:0] data_q, data_d;

  logic [CmpW-1:0] my_idx, pos_c, cnt_c;
  logic            at_pos, live, hit, rd_cmd;

  assign my_idx = CmpW'(INDEX);
  assign pos_c  = CmpW'(ctl_i.pos);
  assign cnt_c  = CmpW'(count_i);
  assign at_pos = (my_idx == pos_c);
  assign live   = (my_idx < cnt_c);
  assign rd_cmd = (ctl_i.cmd == CMD_GET) || (ctl_i.cmd == CMD_REMOVE);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.do_ins) begin
      if (at_pos) begin
        entry_d = value_i;
      end else if (my_idx > pos_c) begin
        entry_d = left_i;
      end
    end else if (ctl_i.do_rem && (my_idx >= pos_c)) begin
      entry_d = right_i;
    end
  end

  // Only the first matching live cell marks the token.
  assign hit = tok_flags_i.valid && !tok_flags_i.found && (ctl_i.cmd == CMD_FIND) &&
               live && (entry_q == value_i);

  always_comb begin
    flags_d.valid = tok_flags_i.valid;
    flags_d.found = tok_flags_i.found || hit;
    idx_d         = hit ? IdxW'(INDEX) : tok_idx_i;
    data_d        = (tok_flags_i.valid && at_pos && rd_cmd) ? entry_q : tok_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    idx_q   <= idx_d;
    data_q  <= data_d;
  end

  assign entry_o     = entry_q;
  assign tok_flags_o = flags_q;
  assign tok_idx_o   = idx_q;
  assign tok_data_o  = data_q;

endmodule

/* sv/positional_list_engine.sv */
// Top level of the positional list engine: command sequencer, entry count,
// result register and the chain of plc_cell instances.
// Depends on plc_pkg and plc_cell.
//
//   channel  | valid      | ready      | beat
//   ---------+------------+------------+-----------------------
//   command  | in_valid_i | in_ready_o | in_data_i  (in_beat_t)
//   result   | out_valid_o| out_ready_i| out_data_o (out_beat_t)
//
// For each command a scan token walks the cell chain one cell per cycle to
// read, compare and find, then the shift and the count update land in the
// same cycle and the result moves to the output register.
// Reset clears the count and the control state; stored entries are not reset.
// A stalled result sits in the output register while the next command is
// already accepted and scanned.
module positional_list_engine import plc_pkg::*; #(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned ENTRY_WIDTH = EntryWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int unsigned CntW    = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW    = $clog2(CAPACITY);
  localparam int unsigned CmpW    = (CntW > 5) ? CntW : 5;
  localparam int unsigned ValExtW = (ENTRY_WIDTH > 32) ? ENTRY_WIDTH : 32;
  localparam int unsigned IdxExtW = (IdxW > 4) ? IdxW : 4;
  localparam int unsigned CntExtW = (CntW > 5) ? CntW : 5;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   start_q;
  logic                   out_valid_q, out_valid_d;
  out_beat_t              out_q, out_d;
  out_beat_t              res_q, res_d;
  logic [2:0]             cmd_q;
  logic [4:0]             pos_q;
  logic [ENTRY_WIDTH-1:0] value_q;
  logic [ValExtW-1:0]     value_ext;

  logic accept;

  // Chain wiring.
  cell_ctl_t              ctl;
  logic [ENTRY_WIDTH-1:0] ent      [CAPACITY];
  tok_flags_t             tok_flags[CAPACITY+1];
  logic [IdxW-1:0]        tok_idx  [CAPACITY+1];
  logic [ENTRY_WIDTH-1:0] tok_data [CAPACITY+1];

  // Result assembly.
  logic [CmpW-1:0]    pos_c, cnt_c;
  logic [CntW-1:0]    cnt_next;
  logic [1:0]         status;
  logic               rd_sel, ins_ok, rem_ok, last_valid;
  logic [ValExtW-1:0] rd_ext;
  logic [IdxExtW-1:0] idx_ext;
  logic [CntExtW-1:0] cnt_ext;
  logic [CAPACITY-1:0] tok_vec;

  assign accept    = in_valid_i && in_ready_o;
  assign value_ext = ValExtW'(in_data_i.value);

  assign tok_flags[0] = '{valid: start_q, found: 1'b0};
  assign tok_idx[0]   = '0;
  assign tok_data[0]  = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = ent[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = ent[g+1];
    end

    plc_cell #(
      .CAPACITY    (CAPACITY),
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .INDEX       (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .count_i     (count_q),
      .value_i     (value_q),
      .left_i      (left),
      .right_i     (right),
      .entry_o     (ent[g]),
      .tok_flags_i (tok_flags[g]),
      .tok_idx_i   (tok_idx[g]),
      .tok_data_i  (tok_data[g]),
      .tok_flags_o (tok_flags[g+1]),
      .tok_idx_o   (tok_idx[g+1]),
      .tok_data_o  (tok_data[g+1])
    );

    assign tok_vec[g] = tok_flags[g+1].valid;
  end

  assign last_valid = tok_flags[CAPACITY].valid;

  // Outcome of the current command, from the finished token and the count.
  assign pos_c = CmpW'(pos_q);
  assign cnt_c = CmpW'(count_q);

  always_comb begin
    status   = ST_OK;
    rd_sel   = 1'b0;
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    cnt_next = count_q;
    unique case (cmd_q)
      CMD_INSERT: begin
        if (pos_c > cnt_c) begin
          status = ST_RANGE;
        end else if (cnt_c >= CmpW'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          ins_ok   = 1'b1;
          cnt_next = CntW'(count_q + 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (pos_c >= cnt_c) begin
          status = ST_RANGE;
        end else begin
          rem_ok   = 1'b1;
          rd_sel   = 1'b1;
          cnt_next = CntW'(count_q - 1'b1);
        end
      end
      CMD_GET: begin
        if (pos_c >= cnt_c) begin
          status = ST_RANGE;
        end else begin
          rd_sel = 1'b1;
        end
      end
      CMD_FIND: begin
        if (!tok_flags[CAPACITY].found) begin
          status = ST_NOTFOUND;
        end
      end
      CMD_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign rd_ext  = ValExtW'(tok_data[CAPACITY]);
  assign idx_ext = IdxExtW'(tok_idx[CAPACITY]);
  assign cnt_ext = CntExtW'(cnt_next);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    ctl.cmd     = cmd_q;
    ctl.pos     = pos_q;
    ctl.do_ins  = 1'b0;
    ctl.do_rem  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_valid) begin
          ctl.do_ins        = ins_ok;
          ctl.do_rem        = rem_ok;
          count_d           = cnt_next;
          res_d.status      = status;
          res_d.read_value  = rd_sel ? rd_ext[31:0] : '0;
          res_d.found_index = ((cmd_q == CMD_FIND) && tok_flags[CAPACITY].found) ?
                              idx_ext[3:0] : '0;
          res_d.entry_count = cnt_ext[4:0];
          state_d           = S_PEND;
        end
      end
      S_PEND: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      start_q     <= accept;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
    if (accept) begin
      cmd_q   <= in_data_i.cmd;
      pos_q   <= in_data_i.position;
      value_q <= value_ext[ENTRY_WIDTH-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The count never passes the store size.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // At most one scan token is in the chain.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one scan token in flight");

  // No token is left in the chain while a new command may enter.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (tok_vec == '0) && !start_q)
    else $error("scan token present while idle");

  // Shifts happen only when the token has finished its walk.
  a_shift_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.do_ins || ctl.do_rem) |-> last_valid && (state_q == S_SCAN))
    else $error("entry shift outside the update cycle");

endmodule
